// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on nothing; bodies collapse to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BQLC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BQLC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BQLC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BQLC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/bqlc_pkg.sv =====
// Types, constants, microcode and saturation helpers for the coefficient smoother.
// No dependencies.
package bqlc_pkg;

    localparam int NUM_COEFFS   = 8;
    localparam int REPORTED     = 8;
    // Ramp length in samples; must be a power of two.
    localparam int BLOCK_LENGTH = 32;
    localparam int BL_SHIFT     = $clog2(BLOCK_LENGTH);
    localparam int CI_W         = $clog2(NUM_COEFFS);

    localparam logic signed [31:0] Q_ONE       = 32'sh0100_0000;
    localparam logic signed [31:0] Q_HALF      = 32'sh0080_0000;
    localparam logic signed [31:0] Q_ZERO      = 32'sh0000_0000;
    localparam logic signed [31:0] Q_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN       = 32'sh8000_0000;
    localparam logic signed [31:0] AI_FLOOR    = 32'sd16;
    localparam logic signed [31:0] SMOOTH_TAKE = 32'sd3355443;
    localparam logic signed [31:0] SMOOTH_KEEP = 32'sd13421773;

    localparam logic [1:0] OPN_LATTICE = 2'd0;
    localparam logic [1:0] OPN_COUPLED = 2'd1;
    localparam logic [1:0] OPN_RESTART = 2'd2;
    localparam logic [1:0] OPN_UNUSED  = 2'd3;

    localparam int DIV_STEPS  = 56;
    localparam int SQRT_STEPS = 28;

    localparam int RF_DEPTH = 24;
    localparam int PC_W     = 6;
    localparam logic [PC_W-1:0] COUPLED_START = 6'd40;
    localparam logic [PC_W-1:0] PC_LAST       = 6'd61;

    // Register file map
    localparam logic [4:0] R_INV  = 5'd0;
    localparam logic [4:0] R_A1   = 5'd1;
    localparam logic [4:0] R_A2   = 5'd2;
    localparam logic [4:0] R_B0   = 5'd3;
    localparam logic [4:0] R_B1   = 5'd4;
    localparam logic [4:0] R_B2   = 5'd5;
    localparam logic [4:0] R_G    = 5'd6;
    localparam logic [4:0] R_T7   = 5'd7;
    localparam logic [4:0] R_T8   = 5'd8;
    localparam logic [4:0] R_T9   = 5'd9;
    localparam logic [4:0] R_T10  = 5'd10;
    localparam logic [4:0] R_T11  = 5'd11;
    localparam logic [4:0] R_T12  = 5'd12;
    localparam logic [4:0] R_ZERO = 5'd13;
    localparam logic [4:0] R_HALF = 5'd14;
    localparam logic [4:0] R_ONE  = 5'd15;
    localparam logic [4:0] NC_BASE = 5'd16;
    localparam logic [4:0] R_N0   = 5'd16;
    localparam logic [4:0] R_N1   = 5'd17;
    localparam logic [4:0] R_N2   = 5'd18;
    localparam logic [4:0] R_N3   = 5'd19;
    localparam logic [4:0] R_N4   = 5'd20;
    localparam logic [4:0] R_N5   = 5'd21;
    localparam logic [4:0] R_N6   = 5'd22;
    localparam logic [4:0] R_N7   = 5'd23;

    localparam logic [4:0] K_ZERO = 5'd0;
    localparam logic [4:0] K_ONE  = 5'd1;
    localparam logic [4:0] K_HALF = 5'd2;

    typedef enum logic [3:0] {
        UOP_LDIN, UOP_LDK, UOP_MUL, UOP_ADD, UOP_SUB, UOP_ABS, UOP_NEG,
        UOP_MIN0, UOP_FLOOR, UOP_SHL2, UOP_DIV, UOP_SQRT, UOP_JMPC, UOP_END
    } t_uop;

    typedef struct packed {
        t_uop       op;
        logic [4:0] dst;
        logic [4:0] sa;
        logic [4:0] sb;
    } t_uinst;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] pole_norm;
        logic signed [31:0] den_one;
        logic signed [31:0] den_two;
        logic signed [31:0] num_zero;
        logic signed [31:0] num_one;
        logic signed [31:0] num_two;
        logic signed [31:0] clip_gain;
    } t_req;

    typedef struct packed {
        logic [2:0]         coeff_index;
        logic signed [31:0] target_value;
        logic signed [31:0] ramp_step;
        logic               last;
    } t_res;

    function automatic logic signed [31:0] f_sat(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'(Q_MAX)) y = Q_MAX;
        else if (x < 64'(Q_MIN)) y = Q_MIN;
        else y = x[31:0];
        return y;
    endfunction

    function automatic t_uinst f_ui(input t_uop op, input logic [4:0] dst,
                                    input logic [4:0] sa, input logic [4:0] sb);
        t_uinst u;
        u.op = op; u.dst = dst; u.sa = sa; u.sb = sb;
        return u;
    endfunction

    // Prologue loads and normalises, then one of two programmes runs.
    function automatic t_uinst f_ucode(input logic [PC_W-1:0] pc);
        t_uinst u;
        case (pc)
            6'd0:  u = f_ui(UOP_LDIN, R_INV, 5'd0, R_ZERO);
            6'd1:  u = f_ui(UOP_LDIN, R_A1, 5'd1, R_ZERO);
            6'd2:  u = f_ui(UOP_LDIN, R_A2, 5'd2, R_ZERO);
            6'd3:  u = f_ui(UOP_LDIN, R_B0, 5'd3, R_ZERO);
            6'd4:  u = f_ui(UOP_LDIN, R_B1, 5'd4, R_ZERO);
            6'd5:  u = f_ui(UOP_LDIN, R_B2, 5'd5, R_ZERO);
            6'd6:  u = f_ui(UOP_LDIN, R_G, 5'd6, R_ZERO);
            6'd7:  u = f_ui(UOP_LDK, R_ZERO, K_ZERO, R_ZERO);
            6'd8:  u = f_ui(UOP_LDK, R_ONE, K_ONE, R_ZERO);
            6'd9:  u = f_ui(UOP_LDK, R_HALF, K_HALF, R_ZERO);
            6'd10: u = f_ui(UOP_MUL, R_A1, R_A1, R_INV);
            6'd11: u = f_ui(UOP_MUL, R_A2, R_A2, R_INV);
            6'd12: u = f_ui(UOP_MUL, R_B0, R_B0, R_INV);
            6'd13: u = f_ui(UOP_MUL, R_B1, R_B1, R_INV);
            6'd14: u = f_ui(UOP_MUL, R_B2, R_B2, R_INV);
            6'd15: u = f_ui(UOP_JMPC, R_ZERO, R_ZERO, R_ZERO);
            // normalised lattice
            6'd16: u = f_ui(UOP_ADD, R_T7, R_ONE, R_A2);
            6'd17: u = f_ui(UOP_DIV, R_N0, R_A1, R_T7);
            6'd18: u = f_ui(UOP_ADD, R_N1, R_A2, R_ZERO);
            6'd19: u = f_ui(UOP_MUL, R_T8, R_N0, R_N0);
            6'd20: u = f_ui(UOP_SUB, R_T8, R_ONE, R_T8);
            6'd21: u = f_ui(UOP_ABS, R_T8, R_T8, R_ZERO);
            6'd22: u = f_ui(UOP_SQRT, R_N2, R_T8, R_ZERO);
            6'd23: u = f_ui(UOP_MUL, R_T9, R_A2, R_A2);
            6'd24: u = f_ui(UOP_SUB, R_T9, R_ONE, R_T9);
            6'd25: u = f_ui(UOP_ABS, R_T9, R_T9, R_ZERO);
            6'd26: u = f_ui(UOP_SQRT, R_N3, R_T9, R_ZERO);
            6'd27: u = f_ui(UOP_ADD, R_N6, R_B2, R_ZERO);
            6'd28: u = f_ui(UOP_MUL, R_T10, R_A1, R_B2);
            6'd29: u = f_ui(UOP_SUB, R_T10, R_B1, R_T10);
            6'd30: u = f_ui(UOP_DIV, R_N5, R_T10, R_N3);
            6'd31: u = f_ui(UOP_MUL, R_T11, R_N0, R_N5);
            6'd32: u = f_ui(UOP_MUL, R_T11, R_T11, R_N3);
            6'd33: u = f_ui(UOP_SUB, R_T11, R_B0, R_T11);
            6'd34: u = f_ui(UOP_MUL, R_T12, R_A2, R_B2);
            6'd35: u = f_ui(UOP_SUB, R_T11, R_T11, R_T12);
            6'd36: u = f_ui(UOP_MUL, R_T12, R_N2, R_N3);
            6'd37: u = f_ui(UOP_DIV, R_N4, R_T11, R_T12);
            6'd38: u = f_ui(UOP_ADD, R_N7, R_G, R_ZERO);
            6'd39: u = f_ui(UOP_END, R_ZERO, R_ZERO, R_ZERO);
            // coupled form
            6'd40: u = f_ui(UOP_MUL, R_T7, R_A1, R_A1);
            6'd41: u = f_ui(UOP_SHL2, R_T8, R_A2, R_ZERO);
            6'd42: u = f_ui(UOP_SUB, R_T7, R_T7, R_T8);
            6'd43: u = f_ui(UOP_MIN0, R_T7, R_T7, R_ZERO);
            6'd44: u = f_ui(UOP_NEG, R_T7, R_T7, R_ZERO);
            6'd45: u = f_ui(UOP_SQRT, R_T7, R_T7, R_ZERO);
            6'd46: u = f_ui(UOP_MUL, R_T7, R_HALF, R_T7);
            6'd47: u = f_ui(UOP_FLOOR, R_N1, R_T7, R_ZERO);
            6'd48: u = f_ui(UOP_NEG, R_T8, R_A1, R_ZERO);
            6'd49: u = f_ui(UOP_MUL, R_N0, R_HALF, R_T8);
            6'd50: u = f_ui(UOP_ADD, R_N2, R_ONE, R_ZERO);
            6'd51: u = f_ui(UOP_ADD, R_N3, R_ZERO, R_ZERO);
            6'd52: u = f_ui(UOP_MUL, R_T9, R_A1, R_B0);
            6'd53: u = f_ui(UOP_SUB, R_N4, R_B1, R_T9);
            6'd54: u = f_ui(UOP_MUL, R_T10, R_A2, R_B0);
            6'd55: u = f_ui(UOP_SUB, R_T10, R_B2, R_T10);
            6'd56: u = f_ui(UOP_MUL, R_T11, R_N4, R_N0);
            6'd57: u = f_ui(UOP_ADD, R_T11, R_T11, R_T10);
            6'd58: u = f_ui(UOP_DIV, R_N5, R_T11, R_N1);
            6'd59: u = f_ui(UOP_ADD, R_N6, R_B0, R_ZERO);
            6'd60: u = f_ui(UOP_ADD, R_N7, R_G, R_ZERO);
            default: u = f_ui(UOP_END, R_ZERO, R_ZERO, R_ZERO);
        endcase
        return u;
    endfunction

endpackage

// ===== sv/bqlc_if.sv =====
// Request and result channel interfaces for the coefficient smoother.
// Depends on bqlc_pkg.
interface bqlc_req_if;
    logic              valid;
    logic              ready;
    bqlc_pkg::t_req    payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bqlc_res_if;
    logic              valid;
    logic              ready;
    bqlc_pkg::t_res    payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/biquad_to_lattice_coeff_smoother_top.sv =====
// Lattice and coupled-form updates run on the microcoded sequencer, using one multiplier,
// a 56-step divider and a 28-step root.
// One update at a time; restart and unused codes are taken without leaving idle.
// Eight results leave through an output register.
// Synchronous active-low reset: idle, first-update flag set, both stores cleared.
// Depends on bqlc_pkg, bqlc_if and assert_macros.svh.
`include "assert_macros.svh"

module biquad_to_lattice_coeff_smoother_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bqlc_req_if.sink          i_req,
    bqlc_res_if.source        o_res
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_FETCH = 11'b000_0000_0010,
        S_EXEC  = 11'b000_0000_0100,
        S_MULW  = 11'b000_0000_1000,
        S_DIV   = 11'b000_0001_0000,
        S_SQRT  = 11'b000_0010_0000,
        S_SM_RD = 11'b000_0100_0000,
        S_SM_A  = 11'b000_1000_0000,
        S_SM_B  = 11'b001_0000_0000,
        S_SM_C  = 11'b010_0000_0000,
        S_SM_D  = 11'b100_0000_0000
    } t_state;

    localparam logic [bqlc_pkg::CI_W-1:0] CI_LAST = bqlc_pkg::CI_W'(bqlc_pkg::REPORTED - 1);

    t_state r_state, n_state;
    logic [bqlc_pkg::PC_W-1:0] r_pc, n_pc;
    bqlc_pkg::t_uinst uc;

    logic signed [31:0] r_field [0:6];
    logic               r_coupled;

    logic signed [31:0] r_rf [0:bqlc_pkg::RF_DEPTH-1];
    logic signed [31:0] r_a, r_b;
    logic [4:0]         rd_a;
    logic               rf_we;
    logic signed [31:0] rf_wd;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p, r_prod, r_acc;

    logic [55:0] r_num, r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;

    logic signed [31:0] r_tgt [0:bqlc_pkg::NUM_COEFFS-1];
    logic signed [31:0] r_cur [0:bqlc_pkg::NUM_COEFFS-1];
    logic               r_first;
    logic [bqlc_pkg::CI_W-1:0] r_ci;
    logic signed [31:0] r_newt;

    logic           r_out_valid;
    bqlc_pkg::t_res r_out;

    logic req_fire, out_free, uop_simple;
    logic signed [31:0] alu_y;
    logic [31:0] ua, ud;
    logic [32:0] div_rem_s, div_rem_n, sq_rem_s, sq_rem_n, sq_trial;
    logic        div_ge, sq_ge;
    logic [55:0] div_q_n, sq_q_n;
    logic signed [31:0] div_y, div_zero_y, t_now;
    logic signed [32:0] diff;
    logic [33:0]        mag, rq;
    logic signed [31:0] ramp;

    assign uc        = bqlc_pkg::f_ucode(r_pc);
    assign req_fire  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free  = !r_out_valid || o_res.ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    assign uop_simple = (uc.op == bqlc_pkg::UOP_LDIN) || (uc.op == bqlc_pkg::UOP_LDK) ||
                        (uc.op == bqlc_pkg::UOP_ADD) || (uc.op == bqlc_pkg::UOP_SUB) ||
                        (uc.op == bqlc_pkg::UOP_ABS) || (uc.op == bqlc_pkg::UOP_NEG) ||
                        (uc.op == bqlc_pkg::UOP_MIN0) || (uc.op == bqlc_pkg::UOP_FLOOR) ||
                        (uc.op == bqlc_pkg::UOP_SHL2);

    // Combinational ALU
    always_comb begin
        unique case (uc.op)
            bqlc_pkg::UOP_LDIN:  alu_y = r_field[uc.sa[2:0]];
            bqlc_pkg::UOP_LDK: begin
                if (uc.sa == bqlc_pkg::K_ONE) alu_y = bqlc_pkg::Q_ONE;
                else if (uc.sa == bqlc_pkg::K_HALF) alu_y = bqlc_pkg::Q_HALF;
                else alu_y = bqlc_pkg::Q_ZERO;
            end
            bqlc_pkg::UOP_ADD:   alu_y = bqlc_pkg::f_sat(64'(r_a) + 64'(r_b));
            bqlc_pkg::UOP_SUB:   alu_y = bqlc_pkg::f_sat(64'(r_a) - 64'(r_b));
            bqlc_pkg::UOP_ABS:   alu_y = r_a[31] ? bqlc_pkg::f_sat(-64'(r_a)) : r_a;
            bqlc_pkg::UOP_NEG:   alu_y = bqlc_pkg::f_sat(-64'(r_a));
            bqlc_pkg::UOP_MIN0:  alu_y = (r_a > bqlc_pkg::Q_ZERO) ? bqlc_pkg::Q_ZERO : r_a;
            bqlc_pkg::UOP_FLOOR: alu_y = (r_a < bqlc_pkg::AI_FLOOR) ? bqlc_pkg::AI_FLOOR : r_a;
            bqlc_pkg::UOP_SHL2:  alu_y = bqlc_pkg::f_sat(64'(r_a) <<< 2);
            default:             alu_y = r_a;
        endcase
    end

    // Shared multiplier
    always_comb begin
        unique case (r_state)
            S_SM_A: begin
                mul_a = r_tgt[r_ci];
                mul_b = bqlc_pkg::SMOOTH_KEEP;
            end
            S_SM_B: begin
                mul_a = r_a;
                mul_b = bqlc_pkg::SMOOTH_TAKE;
            end
            default: begin
                mul_a = r_a;
                mul_b = r_b;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Divider and root steps, one quotient or root bit a cycle
    assign ua = r_a[31] ? 32'(-r_a) : 32'(r_a);
    assign ud = r_b[31] ? 32'(-r_b) : 32'(r_b);
    assign div_rem_s = {r_rem[31:0], r_num[55]};
    assign div_ge    = (div_rem_s >= {1'b0, r_den});
    assign div_rem_n = div_ge ? (div_rem_s - {1'b0, r_den}) : div_rem_s;
    assign div_q_n   = {r_q[54:0], div_ge};
    assign sq_rem_s  = {r_rem[30:0], r_num[55:54]};
    assign sq_trial  = {3'b000, r_q[27:0], 2'b01};
    assign sq_ge     = (sq_rem_s >= sq_trial);
    assign sq_rem_n  = sq_ge ? (sq_rem_s - sq_trial) : sq_rem_s;
    assign sq_q_n    = {r_q[54:0], sq_ge};

    always_comb begin
        if (r_neg) begin
            div_y = (div_q_n > 56'h0000_0080_000000) ? bqlc_pkg::Q_MIN : 32'(-div_q_n);
        end else begin
            div_y = (div_q_n > 56'h0000_007F_FFFFFF) ? bqlc_pkg::Q_MAX : div_q_n[31:0];
        end
        if (r_a > bqlc_pkg::Q_ZERO) div_zero_y = bqlc_pkg::Q_MAX;
        else if (r_a < bqlc_pkg::Q_ZERO) div_zero_y = bqlc_pkg::Q_MIN;
        else div_zero_y = bqlc_pkg::Q_ZERO;
    end

    // Register file write port
    always_comb begin
        rf_we = 1'b0;
        rf_wd = alu_y;
        unique case (r_state)
            S_EXEC: begin
                if (uop_simple) rf_we = 1'b1;
                if (uc.op == bqlc_pkg::UOP_DIV && r_b == bqlc_pkg::Q_ZERO) begin
                    rf_we = 1'b1;
                    rf_wd = div_zero_y;
                end
            end
            S_MULW: begin
                rf_we = 1'b1;
                rf_wd = bqlc_pkg::f_sat((r_prod + 64'sd8388608) >>> 24);
            end
            S_DIV: begin
                rf_we = (r_cnt == 6'(bqlc_pkg::DIV_STEPS - 1));
                rf_wd = div_y;
            end
            S_SQRT: begin
                rf_we = (r_cnt == 6'(bqlc_pkg::SQRT_STEPS - 1));
                rf_wd = {4'b0000, sq_q_n[27:0]};
            end
            default: rf_we = 1'b0;
        endcase
    end

    assign rd_a = (r_state == S_SM_RD || r_state == S_SM_A || r_state == S_SM_B ||
                   r_state == S_SM_C || r_state == S_SM_D) ?
                  5'(bqlc_pkg::NC_BASE + 5'(r_ci)) : uc.sa;

    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[uc.dst] <= rf_wd;
        r_a <= r_rf[rd_a];
        r_b <= r_rf[uc.sb];
    end

    // Ramp toward the new target, rounded half away from zero
    always_comb begin
        t_now = r_first ? r_a : r_newt;
        diff  = 33'(t_now) - 33'(r_cur[r_ci]);
        mag   = diff[32] ? 34'(-34'(diff)) : 34'(diff);
        rq    = (mag + 34'(bqlc_pkg::BLOCK_LENGTH / 2)) >> bqlc_pkg::BL_SHIFT;
        if (r_first) ramp = bqlc_pkg::Q_ZERO;
        else ramp = diff[32] ? 32'(-rq) : rq[31:0];
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire && (i_req.payload.operation == bqlc_pkg::OPN_LATTICE ||
                                 i_req.payload.operation == bqlc_pkg::OPN_COUPLED)) begin
                    n_state = S_FETCH;
                    n_pc    = '0;
                end
            end
            S_FETCH: n_state = S_EXEC;
            S_EXEC: begin
                unique case (uc.op)
                    bqlc_pkg::UOP_MUL:  n_state = S_MULW;
                    bqlc_pkg::UOP_SQRT: n_state = S_SQRT;
                    bqlc_pkg::UOP_DIV: begin
                        if (r_b == bqlc_pkg::Q_ZERO) begin
                            n_state = S_FETCH;
                            n_pc    = r_pc + 1'b1;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    bqlc_pkg::UOP_JMPC: begin
                        n_state = S_FETCH;
                        n_pc    = r_coupled ? bqlc_pkg::COUPLED_START : r_pc + 1'b1;
                    end
                    bqlc_pkg::UOP_END: n_state = S_SM_RD;
                    default: begin
                        n_state = S_FETCH;
                        n_pc    = r_pc + 1'b1;
                    end
                endcase
            end
            S_MULW: begin
                n_state = S_FETCH;
                n_pc    = r_pc + 1'b1;
            end
            S_DIV: begin
                if (r_cnt == 6'(bqlc_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FETCH;
                    n_pc    = r_pc + 1'b1;
                end
            end
            S_SQRT: begin
                if (r_cnt == 6'(bqlc_pkg::SQRT_STEPS - 1)) begin
                    n_state = S_FETCH;
                    n_pc    = r_pc + 1'b1;
                end
            end
            S_SM_RD: n_state = S_SM_A;
            S_SM_A:  n_state = S_SM_B;
            S_SM_B:  n_state = S_SM_C;
            S_SM_C:  n_state = S_SM_D;
            S_SM_D: begin
                if (out_free) begin
                    n_state = (r_ci == CI_LAST) ? S_IDLE : S_SM_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (req_fire) begin
            r_field[0] <= i_req.payload.pole_norm;
            r_field[1] <= i_req.payload.den_one;
            r_field[2] <= i_req.payload.den_two;
            r_field[3] <= i_req.payload.num_zero;
            r_field[4] <= i_req.payload.num_one;
            r_field[5] <= i_req.payload.num_two;
            r_field[6] <= i_req.payload.clip_gain;
            r_coupled  <= (i_req.payload.operation == bqlc_pkg::OPN_COUPLED);
        end
        unique case (r_state)
            S_EXEC: begin
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
                r_den <= ud;
                r_neg <= r_a[31] ^ r_b[31];
                if (uc.op == bqlc_pkg::UOP_SQRT) begin
                    r_num <= (r_a > bqlc_pkg::Q_ZERO) ? {r_a, 24'h000000} : '0;
                end else begin
                    r_num <= {ua, 24'h000000} + 56'(ud >> 1);
                end
            end
            S_DIV: begin
                r_rem <= div_rem_n;
                r_q   <= div_q_n;
                r_num <= r_num << 1;
                r_cnt <= r_cnt + 1'b1;
            end
            S_SQRT: begin
                r_rem <= sq_rem_n;
                r_q   <= sq_q_n;
                r_num <= r_num << 2;
                r_cnt <= r_cnt + 1'b1;
            end
            S_SM_B:  r_acc  <= r_prod;
            S_SM_C:  r_newt <= bqlc_pkg::f_sat((r_acc + r_prod + 64'sd8388608) >>> 24);
            default: r_cnt  <= r_cnt;
        endcase
        if (r_state == S_SM_D && out_free) begin
            r_out.coeff_index  <= 3'(r_ci);
            r_out.target_value <= t_now;
            r_out.ramp_step    <= ramp;
            r_out.last         <= (r_ci == CI_LAST);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_ci        <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            for (int i = 0; i < bqlc_pkg::NUM_COEFFS; i++) begin
                r_tgt[i] <= '0;
                r_cur[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (o_res.ready) r_out_valid <= 1'b0;
            if (req_fire && i_req.payload.operation == bqlc_pkg::OPN_RESTART) begin
                r_first <= 1'b1;
                for (int i = 0; i < bqlc_pkg::NUM_COEFFS; i++) begin
                    r_tgt[i] <= '0;
                    r_cur[i] <= '0;
                end
            end
            if (r_state == S_EXEC && uc.op == bqlc_pkg::UOP_END) r_ci <= '0;
            if (r_state == S_SM_D && out_free) begin
                r_out_valid  <= 1'b1;
                r_tgt[r_ci]  <= t_now;
                if (r_first) r_cur[r_ci] <= t_now;
                // advance, or drop the first-update flag after the last coefficient
                if (r_ci == CI_LAST) r_first <= 1'b0;
                else r_ci <= r_ci + 1'b1;
            end
        end
    end

    `BQLC_ASSERT(a_div_rem_bound, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_rem[32] == 1'b0 && r_rem[31:0] < r_den), "divider remainder out of range")
    `BQLC_ASSERT(a_last_done, i_clk, i_rst_n, (r_state == S_SM_D && out_free && r_ci == CI_LAST) |=> (r_state == S_IDLE && o_res.valid && o_res.payload.last), "run did not end on the last coefficient")
    `BQLC_ASSERT(a_pc_range, i_clk, i_rst_n, (r_state != S_IDLE) |-> (r_pc <= bqlc_pkg::PC_LAST), "microcode counter past programme end")
    `BQLC_NEVER(a_last_index, i_clk, i_rst_n, o_res.valid && o_res.payload.last && o_res.payload.coeff_index != 3'(bqlc_pkg::REPORTED - 1), "last flag on wrong coefficient")

endmodule

// ===== tb/biquad_to_lattice_coeff_smoother_top_tb.sv =====
// Testbench for the biquad-to-lattice coefficient smoother: directed and random requests,
// bit-exact Q8.24 prediction in a scoreboard class, random stalls on both channels.
// Depends on bqlc_pkg, bqlc_if and the RTL top level.
module biquad_to_lattice_coeff_smoother_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0] s64;

    function automatic s64 sat64(input s64 x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // arithmetic shift floors
    function automatic s64 qmul(input s64 a, input s64 b);
        return sat64((a * b + 64'sd8388608) >>> 24);
    endfunction

    function automatic s64 div_round(input s64 n, input s64 d);
        logic [63:0] un, ud, q;
        logic neg;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = (un + ud / 2) / ud;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        return neg ? -s64'(q) : s64'(q);
    endfunction

    function automatic s64 qdiv(input s64 a, input s64 b);
        if (b == 0) return a > 0 ? 64'sd2147483647 : (a < 0 ? -64'sd2147483648 : 0);
        return sat64(div_round(a * 64'sd16777216, b));
    endfunction

    function automatic s64 qroot(input s64 x);
        logic [63:0] v, r, b;
        if (x <= 0) return 0;
        v = 64'(x) << 24;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return sat64(s64'(r));
    endfunction

    function automatic s64 qabs(input s64 a);
        return a < 0 ? sat64(-a) : a;
    endfunction

    class coeff_scoreboard;
        bit fresh;
        s64 tgt[bqlc_pkg::NUM_COEFFS];
        s64 cur[bqlc_pkg::NUM_COEFFS];
        bqlc_pkg::t_res pending[$];
        int errors;

        function void clear_state();
            fresh = 1;
            foreach (tgt[i]) begin
                tgt[i] = 0;
                cur[i] = 0;
            end
        endfunction

        function void note_request(input bqlc_pkg::t_req r);
            s64 nc[bqlc_pkg::NUM_COEFFS];
            s64 inv, a1, a2, b0, b1, b2, g, k1, q1, q2, v2, num, sq, ar, ai, c1, bb2;
            s64 ramp;
            bqlc_pkg::t_res e;
            inv = r.pole_norm;
            a1 = qmul(r.den_one, inv);
            a2 = qmul(r.den_two, inv);
            b0 = qmul(r.num_zero, inv);
            b1 = qmul(r.num_one, inv);
            b2 = qmul(r.num_two, inv);
            g = r.clip_gain;
            if (r.operation == bqlc_pkg::OPN_RESTART) begin
                clear_state();
                return;
            end
            if (r.operation != bqlc_pkg::OPN_LATTICE &&
                r.operation != bqlc_pkg::OPN_COUPLED) return;
            foreach (nc[i]) nc[i] = 0;
            if (r.operation == bqlc_pkg::OPN_LATTICE) begin
                k1 = qdiv(a1, sat64(64'sd16777216 + a2));
                q1 = qroot(qabs(sat64(64'sd16777216 - qmul(k1, k1))));
                q2 = qroot(qabs(sat64(64'sd16777216 - qmul(a2, a2))));
                v2 = qdiv(sat64(b1 - qmul(a1, b2)), q2);
                num = sat64(sat64(b0 - qmul(qmul(k1, v2), q2)) - qmul(a2, b2));
                nc[0] = k1; nc[1] = a2; nc[2] = q1; nc[3] = q2;
                nc[4] = qdiv(num, qmul(q1, q2)); nc[5] = v2; nc[6] = b2; nc[7] = g;
            end else begin
                sq = sat64(qmul(a1, a1) - sat64(a2 * 4));
                if (sq > 0) sq = 0;
                ar = qmul(64'sd8388608, sat64(-a1));
                ai = qmul(64'sd8388608, qroot(sat64(-sq)));
                if (ai < 16) ai = 16;
                c1 = sat64(b1 - qmul(a1, b0));
                bb2 = sat64(b2 - qmul(a2, b0));
                nc[0] = ar; nc[1] = ai; nc[2] = 64'sd16777216; nc[3] = 0;
                nc[4] = c1; nc[5] = qdiv(sat64(qmul(c1, ar) + bb2), ai);
                nc[6] = b0; nc[7] = g;
            end
            for (int i = 0; i < bqlc_pkg::NUM_COEFFS; i++) begin
                if (fresh) begin
                    tgt[i] = nc[i];
                    cur[i] = nc[i];
                    ramp = 0;
                end else begin
                    tgt[i] = sat64((tgt[i] * 64'(bqlc_pkg::SMOOTH_KEEP)
                                    + nc[i] * 64'(bqlc_pkg::SMOOTH_TAKE)
                                    + 64'sd8388608) >>> 24);
                    ramp = sat64(div_round(tgt[i] - cur[i], 64'(bqlc_pkg::BLOCK_LENGTH)));
                end
                if (i < bqlc_pkg::REPORTED) begin
                    e.coeff_index = 3'(i);
                    e.target_value = tgt[i][31:0];
                    e.ramp_step = ramp[31:0];
                    e.last = (i == bqlc_pkg::REPORTED - 1);
                    pending.push_back(e);
                end
            end
            fresh = 0;
        endfunction

        function void check_result(input bqlc_pkg::t_res got);
            bqlc_pkg::t_res e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got.coeff_index !== e.coeff_index || got.target_value !== e.target_value ||
                got.ramp_step !== e.ramp_step || got.last !== e.last) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    bqlc_req_if req_ch();
    bqlc_res_if res_ch();
    coeff_scoreboard coeff_sb;
    int idle_cycles = 0;
    bit hold_off = 0;
    bit sink_stalls = 1;

    always #6 i_clk = ~i_clk;

    biquad_to_lattice_coeff_smoother_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_res(res_ch.source)
    );

    initial begin
        req_ch.valid = 0;
        req_ch.payload = '0;
        res_ch.ready = 0;
        coeff_sb = new();
        coeff_sb.clear_state();
    end

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) coeff_sb.note_request(req_ch.payload);
            if (res_ch.valid && res_ch.ready) coeff_sb.check_result(res_ch.payload);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (hold_off) res_ch.ready <= 0;
        else if (!sink_stalls) res_ch.ready <= 1;
        else res_ch.ready <= ($urandom_range(0, 9) < 7);
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return bqlc_pkg::Q_MAX;
            1: return bqlc_pkg::Q_MIN;
            2: return 32'($signed($urandom_range(0, 67108864)) - 33554432);
            3: return bqlc_pkg::Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    // offer one request and hold it until it is taken
    task automatic send_request(input bqlc_pkg::t_req r);
        @(negedge i_clk);
        req_ch.payload <= r;
        req_ch.valid <= 1;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic idle_sender(input int n);
        @(negedge i_clk);
        req_ch.valid <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        idle_sender(0);
        while (coeff_sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic bqlc_pkg::t_req make_request(input logic [1:0] op);
        bqlc_pkg::t_req r;
        r.operation = op;
        r.pole_norm = ($urandom_range(0, 3) == 0) ? rand_q() : bqlc_pkg::Q_ONE;
        r.den_one = rand_q();
        r.den_two = rand_q();
        r.num_zero = rand_q();
        r.num_one = rand_q();
        r.num_two = rand_q();
        r.clip_gain = rand_q();
        return r;
    endfunction

    initial begin
        bqlc_pkg::t_req r;
        int burst;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, both forms, zero divisor, restart, unused code
        r = '{bqlc_pkg::OPN_LATTICE, bqlc_pkg::Q_ONE, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO,
              bqlc_pkg::Q_ONE, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ONE};
        send_request(r);
        r = '{bqlc_pkg::OPN_LATTICE, bqlc_pkg::Q_ONE, bqlc_pkg::Q_ONE, -bqlc_pkg::Q_ONE,
              bqlc_pkg::Q_HALF, bqlc_pkg::Q_HALF, bqlc_pkg::Q_HALF, bqlc_pkg::Q_HALF};
        send_request(r);
        r = '{bqlc_pkg::OPN_LATTICE, bqlc_pkg::Q_MAX, bqlc_pkg::Q_MAX, bqlc_pkg::Q_MAX,
              bqlc_pkg::Q_MAX, bqlc_pkg::Q_MAX, bqlc_pkg::Q_MAX, bqlc_pkg::Q_MAX};
        send_request(r);
        r = '{bqlc_pkg::OPN_LATTICE, bqlc_pkg::Q_MIN, bqlc_pkg::Q_MIN, bqlc_pkg::Q_MIN,
              bqlc_pkg::Q_MIN, bqlc_pkg::Q_MIN, bqlc_pkg::Q_MIN, bqlc_pkg::Q_MIN};
        send_request(r);
        r = '{bqlc_pkg::OPN_LATTICE, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO,
              bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO};
        send_request(r);
        r = '{bqlc_pkg::OPN_UNUSED, bqlc_pkg::Q_MAX, bqlc_pkg::Q_MIN, bqlc_pkg::Q_MAX,
              bqlc_pkg::Q_MIN, bqlc_pkg::Q_MAX, bqlc_pkg::Q_MIN, bqlc_pkg::Q_MAX};
        send_request(r);
        r = '{bqlc_pkg::OPN_RESTART, '1, '1, '1, '1, '1, '1, '1};
        send_request(r);
        r = '{bqlc_pkg::OPN_COUPLED, bqlc_pkg::Q_ONE, -bqlc_pkg::Q_ONE, bqlc_pkg::Q_HALF,
              bqlc_pkg::Q_ONE, bqlc_pkg::Q_HALF, bqlc_pkg::Q_HALF, bqlc_pkg::Q_ONE};
        send_request(r);
        r = '{bqlc_pkg::OPN_COUPLED, bqlc_pkg::Q_ONE, bqlc_pkg::Q_MAX, bqlc_pkg::Q_ZERO,
              bqlc_pkg::Q_MIN, bqlc_pkg::Q_MAX, bqlc_pkg::Q_MIN, bqlc_pkg::Q_MIN};
        send_request(r);
        r = '{bqlc_pkg::OPN_COUPLED, bqlc_pkg::Q_ONE, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_MAX,
              bqlc_pkg::Q_MAX, bqlc_pkg::Q_MIN, bqlc_pkg::Q_MAX, bqlc_pkg::Q_MAX};
        send_request(r);
        r = '{bqlc_pkg::OPN_COUPLED, bqlc_pkg::Q_MIN, bqlc_pkg::Q_MAX, bqlc_pkg::Q_MIN,
              bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO, bqlc_pkg::Q_ZERO};
        send_request(r);
        drain();

        // hold the receiver off while the sender keeps offering
        hold_off = 1;
        fork
            begin
                repeat (3) send_request(make_request(bqlc_pkg::OPN_LATTICE));
                idle_sender(0);
            end
            begin
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
        join
        drain();

        for (int n = 0; n < 55; n++) begin
            burst = $urandom_range(1, 6);
            sink_stalls = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < burst; k++) begin
                case ($urandom_range(0, 19))
                    0: r = make_request(bqlc_pkg::OPN_RESTART);
                    1: r = make_request(bqlc_pkg::OPN_UNUSED);
                    default: r = make_request($urandom_range(0, 1) ?
                                              bqlc_pkg::OPN_COUPLED : bqlc_pkg::OPN_LATTICE);
                endcase
                send_request(r);
            end
            if ($urandom_range(0, 15) == 0) drain();
            else idle_sender($urandom_range(0, 40));
        end
        drain();

        if (coeff_sb.errors == 0 && coeff_sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
